FILE: design/aip_pkg.sv
`timescale 1ns / 1ps

package aip_pkg;

    // result status codes
    localparam logic [1:0] STATUS_OK     = 2'd0;
    localparam logic [1:0] STATUS_SYNTAX = 2'd1;
    localparam logic [1:0] STATUS_RANGE  = 2'd2;

    // range check modes (codes five to seven act as the full int32 range)
    localparam logic [2:0] RANGE_INT32  = 3'd0;
    localparam logic [2:0] RANGE_UINT31 = 3'd1;
    localparam logic [2:0] RANGE_S16    = 3'd2;
    localparam logic [2:0] RANGE_U8     = 3'd3;
    localparam logic [2:0] RANGE_S8     = 3'd4;

    // character codes
    localparam logic [7:0] CHAR_PLUS   = 8'h2B;
    localparam logic [7:0] CHAR_MINUS  = 8'h2D;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;
    localparam logic [7:0] CHAR_LOW_A  = 8'h61;
    localparam logic [7:0] CHAR_LOW_F  = 8'h66;
    localparam logic [7:0] CHAR_UP_A   = 8'h41;
    localparam logic [7:0] CHAR_UP_F   = 8'h46;
    localparam logic [7:0] CHAR_LOW_X  = 8'h78;
    localparam logic [7:0] CHAR_UP_X   = 8'h58;
    localparam logic [7:0] CHAR_SPACE  = 8'h20;
    localparam logic [7:0] CHAR_TAB    = 8'h09;
    localparam logic [7:0] CHAR_CR     = 8'h0D;

    // one result as the parse core hands it to the output stage
    typedef struct packed {
        logic signed [31:0] value;
        logic [1:0]         status;
    } result_t;

endpackage

FILE: design/aip_parse_core.sv
`timescale 1ns / 1ps

module aip_parse_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step_en,
    input  logic [7:0]           character,
    input  logic                 end_marker,
    input  logic [2:0]           range_mode,
    output aip_pkg::result_t     result
);

    typedef enum logic [2:0] {
        PH_LEAD,
        PH_SIGN,
        PH_ZERO,
        PH_HEXSTART,
        PH_DEC,
        PH_HEX,
        PH_TRAIL
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic        neg_reg, neg_next;
    logic        hex_reg, hex_next;
    logic [31:0] mag_reg, mag_next;
    logic        ovf_reg, ovf_next;
    logic        err_reg, err_next;

    // character classes
    logic       is_ws;
    logic       is_dec;
    logic       is_hex_letter;
    logic [3:0] dec_val;
    logic [3:0] hex_val;
    logic       use_hex;
    logic       digit_ok;
    logic [3:0] digit;

    always_comb begin
        is_ws = (character == aip_pkg::CHAR_SPACE)
             || (character >= aip_pkg::CHAR_TAB && character <= aip_pkg::CHAR_CR);
        is_dec = (character >= aip_pkg::CHAR_ZERO) && (character <= aip_pkg::CHAR_NINE);
        is_hex_letter = (character >= aip_pkg::CHAR_LOW_A && character <= aip_pkg::CHAR_LOW_F)
                     || (character >= aip_pkg::CHAR_UP_A && character <= aip_pkg::CHAR_UP_F);
        dec_val = character[3:0];
        // letters a-f and A-F share the low three bits: 1..6 maps to 10..15
        hex_val = 4'd9 + {1'b0, character[2:0]};
        use_hex = (phase_reg == PH_HEXSTART) || (phase_reg == PH_HEX);
        digit_ok = is_dec || (use_hex && is_hex_letter);
        digit = is_dec ? dec_val : hex_val;
    end

    // shift-add accumulate, 36 bits so any carry past 32 is seen
    logic [35:0] mag_ext;
    logic [35:0] acc_sum;

    always_comb begin
        mag_ext = {4'b0, mag_reg};
        if (hex_reg) begin
            acc_sum = (mag_ext << 4) + {32'b0, digit};
        end else begin
            acc_sum = (mag_ext << 3) + (mag_ext << 1) + {32'b0, digit};
        end
    end

    // next parse state for one character
    always_comb begin
        phase_next = phase_reg;
        neg_next   = neg_reg;
        hex_next   = hex_reg;
        mag_next   = mag_reg;
        ovf_next   = ovf_reg;
        err_next   = err_reg;
        if (!err_reg) begin
            case (phase_reg)
                PH_LEAD, PH_SIGN: begin
                    if (phase_reg == PH_LEAD && is_ws) begin
                        phase_next = PH_LEAD;
                    end else if (phase_reg == PH_LEAD && (character == aip_pkg::CHAR_PLUS
                            || character == aip_pkg::CHAR_MINUS)) begin
                        neg_next   = (character == aip_pkg::CHAR_MINUS);
                        phase_next = PH_SIGN;
                    end else if (is_dec) begin
                        mag_next   = {28'b0, dec_val};
                        phase_next = (dec_val == 4'd0) ? PH_ZERO : PH_DEC;
                    end else begin
                        err_next = 1'b1;
                    end
                end
                PH_ZERO: begin
                    if (character == aip_pkg::CHAR_LOW_X || character == aip_pkg::CHAR_UP_X) begin
                        hex_next   = 1'b1;
                        phase_next = PH_HEXSTART;
                    end else if (is_ws) begin
                        phase_next = PH_TRAIL;
                    end else if (is_dec) begin
                        mag_next   = acc_sum[31:0];
                        phase_next = PH_DEC;
                    end else begin
                        err_next = 1'b1;
                    end
                end
                PH_HEXSTART: begin
                    if (digit_ok) begin
                        mag_next   = acc_sum[31:0];
                        phase_next = PH_HEX;
                    end else begin
                        err_next = 1'b1;
                    end
                end
                PH_DEC, PH_HEX: begin
                    if (is_ws) begin
                        phase_next = PH_TRAIL;
                    end else if (digit_ok) begin
                        if (!ovf_reg) begin
                            mag_next = acc_sum[31:0];
                            ovf_next = (acc_sum[35:32] != 4'd0);
                        end
                    end else begin
                        err_next = 1'b1;
                    end
                end
                PH_TRAIL: begin
                    if (!is_ws) begin
                        err_next = 1'b1;
                    end
                end
                default: begin
                    err_next = 1'b1;
                end
            endcase
        end
    end

    // result for an end marker, built from the current state
    logic [31:0] bits;
    logic        in_range;

    always_comb begin
        bits = neg_reg ? (32'd0 - mag_reg) : mag_reg;
        case (range_mode)
            aip_pkg::RANGE_UINT31: in_range = !bits[31];
            aip_pkg::RANGE_S16:    in_range = (bits[31:15] == 17'd0) || (&bits[31:15]);
            aip_pkg::RANGE_U8:     in_range = (bits[31:8] == 24'd0);
            aip_pkg::RANGE_S8:     in_range = (bits[31:7] == 25'd0) || (&bits[31:7]);
            default:               in_range = 1'b1;
        endcase
        if (err_reg || phase_reg == PH_LEAD || phase_reg == PH_SIGN
                || phase_reg == PH_HEXSTART) begin
            result.status = aip_pkg::STATUS_SYNTAX;
            result.value  = '0;
        end else if (ovf_reg || !in_range) begin
            result.status = aip_pkg::STATUS_RANGE;
            result.value  = '0;
        end else begin
            result.status = aip_pkg::STATUS_OK;
            result.value  = bits;
        end
    end

    // parse state; an end marker returns it to reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_LEAD;
            neg_reg   <= 1'b0;
            hex_reg   <= 1'b0;
            mag_reg   <= '0;
            ovf_reg   <= 1'b0;
            err_reg   <= 1'b0;
        end else if (step_en) begin
            if (end_marker) begin
                phase_reg <= PH_LEAD;
                neg_reg   <= 1'b0;
                hex_reg   <= 1'b0;
                mag_reg   <= '0;
                ovf_reg   <= 1'b0;
                err_reg   <= 1'b0;
            end else begin
                phase_reg <= phase_next;
                neg_reg   <= neg_next;
                hex_reg   <= hex_next;
                mag_reg   <= mag_next;
                ovf_reg   <= ovf_next;
                err_reg   <= err_next;
            end
        end
    end

endmodule

FILE: design/ascii_integer_parser_unit.sv
`timescale 1ns / 1ps

// ASCII integer parser: takes one character per transfer on the s_ channel and,
// on a transfer with s_end_marker set, returns one signed 32-bit value and a
// status (0 ok, 1 bad syntax or empty, 2 out of range) on the m_ channel.
// Accepted text is ws* [+-]? (0x hexdigits | decimal digits) ws*, with the
// x and hex letters in either case. range_mode (written with range_mode_we
// while idle) selects the range check: 0 int32, 1 int32 >= 0, 2 s16, 3 u8,
// 4 s8. Throughput is one character per clock: each character passes an
// input register, then one shift-add and phase update against the parse
// state registers. An end marker is held in the input register, then its result
// is loaded into the output register behind m_valid; the input side only stalls
// when an end marker meets an output result that has not yet been taken.
module ascii_integer_parser_unit (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               range_mode_we,
    input  logic [2:0]         range_mode_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_character,
    input  logic               s_end_marker,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_parsed_value,
    output logic [1:0]         m_status
);

    logic [2:0]         range_mode_reg;
    logic               in_valid_reg;
    logic [7:0]         in_char_reg;
    logic               in_end_reg;
    logic               out_valid_reg;
    logic signed [31:0] out_value_reg;
    logic [1:0]         out_status_reg;
    logic               advance;
    aip_pkg::result_t   result;

    // the held item moves on unless it is an end marker blocked by a waiting result
    assign advance = in_valid_reg && (!in_end_reg || !out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            range_mode_reg <= aip_pkg::RANGE_INT32;
        end else if (range_mode_we) begin
            range_mode_reg <= range_mode_wdata;
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_char_reg <= s_character;
            in_end_reg  <= s_end_marker;
        end
    end

    aip_parse_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step_en    (advance),
        .character  (in_char_reg),
        .end_marker (in_end_reg),
        .range_mode (range_mode_reg),
        .result     (result)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && in_end_reg) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_end_reg) begin
            out_value_reg  <= result.value;
            out_status_reg <= result.status;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_parsed_value = out_value_reg;
    assign m_status       = out_status_reg;

endmodule

FILE: design/aip_checker.sv
`timescale 1ns / 1ps

module aip_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [31:0] m_parsed_value,
    input logic [1:0]         m_status
);

    // a stalled result holds its value
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_parsed_value) && $stable(m_status))
        else $error("result changed while stalled");

    // only the three defined status codes come out
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == aip_pkg::STATUS_OK || m_status == aip_pkg::STATUS_SYNTAX
            || m_status == aip_pkg::STATUS_RANGE))
        else $error("undefined status code");

    // a failed parse reports zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != aip_pkg::STATUS_OK |-> m_parsed_value == 32'sd0)
        else $error("nonzero value with error status");

    // no result straight out of reset
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // input side never refuses while the output holds no result
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

endmodule

bind ascii_integer_parser_unit aip_checker u_aip_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_parsed_value (m_parsed_value),
    .m_status       (m_status)
);

FILE: verif/tb_ascii_integer_parser_unit.sv
`timescale 1ns / 1ps

module tb_ascii_integer_parser_unit;

    // spare range codes, checked like the full int32 range
    localparam logic [2:0] RANGE_SPARE5 = 3'd5;
    localparam logic [2:0] RANGE_SPARE6 = 3'd6;
    localparam logic [2:0] RANGE_SPARE7 = 3'd7;

    localparam int SETTLE_CYCLES = 6;
    localparam int TAIL_CYCLES   = 16;
    localparam int STALL_LIMIT   = 4000;

    typedef enum logic [2:0] {
        P_LEAD, P_SIGN, P_ZERO, P_HEXSTART, P_DEC, P_HEX, P_TRAIL
    } scan_phase_t;

    logic               aclk;
    logic               aresetn;
    logic               range_mode_we;
    logic [2:0]         range_mode_wdata;
    logic               s_valid;
    logic               s_ready;
    logic [7:0]         s_character;
    logic               s_end_marker;
    logic               m_valid;
    logic               m_ready;
    logic signed [31:0] m_parsed_value;
    logic [1:0]         m_status;

    // mirror of the parse state
    scan_phase_t ph;
    logic        neg_flag;
    logic        hex_flag;
    logic [32:0] mag;
    logic        ovf_flag;
    logic        syn_flag;
    logic [2:0]  cur_mode;

    aip_pkg::result_t parse_results_due[$];
    aip_pkg::result_t want;
    logic [7:0]  text_buf[$];
    int          fails;
    int          symbols_sent;
    int          quiet_cycles;
    bit          no_stall;

    ascii_integer_parser_unit u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .range_mode_we    (range_mode_we),
        .range_mode_wdata (range_mode_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_character      (s_character),
        .s_end_marker     (s_end_marker),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_parsed_value   (m_parsed_value),
        .m_status         (m_status)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // ---------------- parse predictor ----------------

    function automatic bit is_space(input logic [7:0] c);
        return (c == aip_pkg::CHAR_SPACE)
            || (c >= aip_pkg::CHAR_TAB && c <= aip_pkg::CHAR_CR);
    endfunction

    // digit value, or -1 when c is no digit of the base
    function automatic int digit_value(input logic [7:0] c, input bit hex);
        if (c >= aip_pkg::CHAR_ZERO && c <= aip_pkg::CHAR_NINE)
            return c - aip_pkg::CHAR_ZERO;
        if (hex && c >= aip_pkg::CHAR_LOW_A && c <= aip_pkg::CHAR_LOW_F)
            return c - aip_pkg::CHAR_LOW_A + 10;
        if (hex && c >= aip_pkg::CHAR_UP_A && c <= aip_pkg::CHAR_UP_F)
            return c - aip_pkg::CHAR_UP_A + 10;
        return -1;
    endfunction

    task automatic clear_parse();
        ph       = P_LEAD;
        neg_flag = 1'b0;
        hex_flag = 1'b0;
        mag      = '0;
        ovf_flag = 1'b0;
        syn_flag = 1'b0;
    endtask

    // shift-add, saturating just past 32 bits
    task automatic add_digit(input int d);
        logic [63:0] acc;
        if (ovf_flag)
            return;
        acc = {31'b0, mag} * (hex_flag ? 64'd16 : 64'd10) + d;
        if (acc > 64'hFFFF_FFFF) begin
            ovf_flag = 1'b1;
            mag      = 33'h1_0000_0000;
        end else begin
            mag = acc[32:0];
        end
    endtask

    task automatic scan_character(input logic [7:0] c);
        int d;
        if (syn_flag)
            return;
        case (ph)
            P_LEAD, P_SIGN: begin
                if (ph == P_LEAD && is_space(c))
                    return;
                if (ph == P_LEAD && (c == aip_pkg::CHAR_PLUS || c == aip_pkg::CHAR_MINUS)) begin
                    neg_flag = (c == aip_pkg::CHAR_MINUS);
                    ph = P_SIGN;
                    return;
                end
                d = digit_value(c, 1'b0);
                if (d >= 0) begin
                    mag = 33'(d);
                    if (d == 0)
                        ph = P_ZERO;
                    else
                        ph = P_DEC;
                    return;
                end
            end
            P_ZERO: begin
                if (c == aip_pkg::CHAR_LOW_X || c == aip_pkg::CHAR_UP_X) begin
                    hex_flag = 1'b1;
                    ph = P_HEXSTART;
                    return;
                end
                if (is_space(c)) begin
                    ph = P_TRAIL;
                    return;
                end
                d = digit_value(c, 1'b0);
                if (d >= 0) begin
                    add_digit(d);
                    ph = P_DEC;
                    return;
                end
            end
            P_HEXSTART: begin
                d = digit_value(c, 1'b1);
                if (d >= 0) begin
                    add_digit(d);
                    ph = P_HEX;
                    return;
                end
            end
            P_DEC, P_HEX: begin
                if (is_space(c)) begin
                    ph = P_TRAIL;
                    return;
                end
                d = digit_value(c, ph == P_HEX);
                if (d >= 0) begin
                    add_digit(d);
                    return;
                end
            end
            P_TRAIL: begin
                if (is_space(c))
                    return;
            end
            default: ;
        endcase
        syn_flag = 1'b1;
    endtask

    // end marker: value, status and range check
    task automatic finish_number();
        aip_pkg::result_t   r;
        logic [31:0]        m;
        logic [31:0]        bits;
        logic signed [31:0] v;
        bit                 ok;
        r.status = aip_pkg::STATUS_OK;
        r.value  = '0;
        if (syn_flag || ph == P_LEAD || ph == P_SIGN || ph == P_HEXSTART) begin
            r.status = aip_pkg::STATUS_SYNTAX;
        end else if (ovf_flag) begin
            r.status = aip_pkg::STATUS_RANGE;
        end else begin
            m    = mag[31:0];
            bits = neg_flag ? (32'd0 - m) : m;
            v    = bits;
            case (cur_mode)
                aip_pkg::RANGE_UINT31: ok = (v >= 0);
                aip_pkg::RANGE_S16:    ok = (v >= -32768) && (v <= 32767);
                aip_pkg::RANGE_U8:     ok = (v >= 0) && (v <= 255);
                aip_pkg::RANGE_S8:     ok = (v >= -128) && (v <= 127);
                default:               ok = 1'b1;
            endcase
            if (ok)
                r.value = v;
            else
                r.status = aip_pkg::STATUS_RANGE;
        end
        parse_results_due.push_back(r);
        clear_parse();
    endtask

    // ---------------- monitor, checker and watchdog ----------------

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_parse();
            cur_mode     = aip_pkg::RANGE_INT32;
            quiet_cycles = 0;
        end else begin
            if (range_mode_we)
                cur_mode = range_mode_wdata;

            // input transfer
            if (s_valid && s_ready) begin
                if (s_end_marker)
                    finish_number();
                else
                    scan_character(s_character);
            end

            // result transfer
            if (m_valid && m_ready) begin
                if (parse_results_due.size() == 0) begin
                    $error("unexpected result: parsed_value %0d, status %0d",
                           m_parsed_value, m_status);
                    fails++;
                end else begin
                    want = parse_results_due.pop_front();
                    if (m_parsed_value !== want.value) begin
                        $error("parsed_value mismatch: expected %0d, actual %0d",
                               want.value, m_parsed_value);
                        fails++;
                    end
                    if (m_status !== want.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, m_status);
                        fails++;
                    end
                end
            end

            // stall watchdog
            if ((s_valid && s_ready) || (m_valid && m_ready) || range_mode_we)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("** ascii_integer_parser_unit: FAILED **");
                $finish;
            end
        end
    end

    // ---------------- stimulus helpers ----------------

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        if (no_stall)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // receiver back-pressure
    initial begin
        int hold;
        m_ready = 1'b0;
        forever begin
            hold = pick_gap();
            repeat (hold) begin
                @(negedge aclk);
                m_ready <= 1'b0;
            end
            hold = $urandom_range(1, 12);
            repeat (hold) begin
                @(negedge aclk);
                m_ready <= 1'b1;
            end
        end
    end

    // one transfer on the input channel, after a random gap
    task automatic push_symbol(input logic [7:0] c, input logic em);
        int idle;
        idle = pick_gap();
        repeat (idle) begin
            @(negedge aclk);
            s_valid      <= 1'b0;
            s_character  <= 8'($urandom_range(0, 255));
            s_end_marker <= 1'($urandom_range(0, 1));
        end
        @(negedge aclk);
        s_valid      <= 1'b1;
        s_character  <= c;
        s_end_marker <= em;
        do @(posedge aclk); while (!s_ready);
        symbols_sent++;
    endtask

    task automatic send_end();
        push_symbol(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_symbol(s[i], 1'b0);
        send_end();
    endtask

    task automatic send_buf();
        foreach (text_buf[i])
            push_symbol(text_buf[i], 1'b0);
        send_end();
    endtask

    // drop valid, wait for every result and let the pipeline empty
    task automatic settle_block();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (parse_results_due.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic set_range_mode(input logic [2:0] mode);
        settle_block();
        @(negedge aclk);
        range_mode_we    <= 1'b1;
        range_mode_wdata <= mode;
        @(negedge aclk);
        range_mode_we    <= 1'b0;
    endtask

    function automatic logic [7:0] random_space();
        int k;
        k = $urandom_range(0, 5);
        if (k == 5)
            return aip_pkg::CHAR_SPACE;
        return 8'(aip_pkg::CHAR_TAB + k);
    endfunction

    function automatic logic [7:0] digit_char(input int d);
        if (d < 10)
            return 8'(aip_pkg::CHAR_ZERO + d);
        if ($urandom_range(0, 1))
            return 8'(aip_pkg::CHAR_UP_A + (d - 10));
        return 8'(aip_pkg::CHAR_LOW_A + (d - 10));
    endfunction

    // magnitudes biased toward the range boundaries
    function automatic logic [63:0] pick_magnitude();
        int          sel;
        logic [63:0] pivot;
        sel = $urandom_range(0, 15);
        case (sel)
            0: return {32'b0, $urandom_range(0, 9)};
            1: return {32'b0, $urandom_range(0, 300)};
            2: return {32'b0, $urandom()};
            3: begin
                pivot = {32'b0, $urandom_range(1, 3)};
                return (pivot << 32) | {32'b0, $urandom()};
            end
            4:  pivot = 64'd127;
            5:  pivot = 64'd128;
            6:  pivot = 64'd255;
            7:  pivot = 64'd256;
            8:  pivot = 64'd32767;
            9:  pivot = 64'd32768;
            10: pivot = 64'h7FFF_FFFF;
            11: pivot = 64'h8000_0000;
            12: pivot = 64'hFFFF_FFFF;
            13: pivot = 64'h1_0000_0000;
            default: pivot = 64'd0;
        endcase
        pivot = pivot + {32'b0, $urandom_range(0, 4)};
        return (pivot >= 2) ? pivot - 2 : 64'd0;
    endfunction

    // random text: mostly well formed numbers, some corrupted, some noise
    task automatic build_text();
        int          kind;
        int          n;
        int          pos;
        int          d;
        bit          as_hex;
        logic [63:0] v;
        logic [7:0]  digits[$];
        text_buf.delete();
        kind = $urandom_range(0, 99);
        if (kind < 6) begin
            n = $urandom_range(0, 6);
            repeat (n) text_buf.push_back(8'($urandom_range(0, 255)));
            return;
        end
        repeat ($urandom_range(0, 2)) text_buf.push_back(random_space());
        case ($urandom_range(0, 2))
            1: text_buf.push_back(aip_pkg::CHAR_PLUS);
            2: text_buf.push_back(aip_pkg::CHAR_MINUS);
            default: ;
        endcase
        v = pick_magnitude();
        as_hex = 1'($urandom_range(0, 1));
        if (as_hex) begin
            text_buf.push_back(aip_pkg::CHAR_ZERO);
            text_buf.push_back($urandom_range(0, 1) ? aip_pkg::CHAR_UP_X : aip_pkg::CHAR_LOW_X);
        end
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 2)) text_buf.push_back(aip_pkg::CHAR_ZERO);
        do begin
            d = as_hex ? int'(v % 16) : int'(v % 10);
            digits.push_front(digit_char(d));
            v = as_hex ? v / 16 : v / 10;
        end while (v != 0);
        foreach (digits[i])
            text_buf.push_back(digits[i]);
        repeat ($urandom_range(0, 2)) text_buf.push_back(random_space());
        if (kind < 16) begin
            pos = $urandom_range(0, text_buf.size() - 1);
            text_buf[pos] = 8'($urandom_range(0, 255));
        end else if (kind < 20) begin
            text_buf.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    // ---------------- tests ----------------

    task automatic test_grammar_cases();
        set_range_mode(aip_pkg::RANGE_INT32);
        send_text("  +42 ");
        send_text("0xFFFFFFFF");
        send_text("-2147483648");
        send_text("4294967296");
        send_text("\011\012\013\014\015 7\011");
        send_text("");
        send_text(" ");
        send_text("-");
        send_text("0x");
        send_text("0Xa1G");
        send_text("1 2");
        send_text("007");
        send_text("0 ");
        send_text("99999999999z");
        send_text("+-1");
        send_text("-0xabcDEF");
        // codes above 127 break the pattern
        push_symbol(8'h80, 1'b0);
        send_end();
        push_symbol(aip_pkg::CHAR_ZERO, 1'b0);
        push_symbol(8'hFF, 1'b0);
        send_end();
    endtask

    task automatic test_range_limits();
        set_range_mode(aip_pkg::RANGE_UINT31);
        send_text("0");
        send_text("-1");
        send_text("2147483647");
        send_text("2147483648");
        set_range_mode(aip_pkg::RANGE_S16);
        send_text("32767");
        send_text("-32768");
        send_text("32768");
        send_text("-32769");
        set_range_mode(aip_pkg::RANGE_U8);
        send_text("255");
        send_text("256");
        send_text("-0");
        send_text("-1");
        set_range_mode(aip_pkg::RANGE_S8);
        send_text("127");
        send_text("-128");
        send_text("128");
        send_text("-129");
    endtask

    task automatic test_spare_modes();
        set_range_mode(RANGE_SPARE5);
        send_text("-7");
        send_text("0xFFFFFFFF");
        set_range_mode(RANGE_SPARE7);
        send_text("-2147483648");
        send_text("0x100000000");
        // a syntax error outranks overflow
        send_text("0x1000000000g");
    endtask

    task automatic test_pause_for_results();
        set_range_mode(aip_pkg::RANGE_INT32);
        repeat (4) begin
            build_text();
            send_buf();
        end
        settle_block();
        repeat (4) begin
            build_text();
            send_buf();
        end
    endtask

    task automatic test_random_text();
        int         target;
        logic [2:0] mode;
        for (int p = 0; p < 8; p++) begin
            case (p)
                0: mode = aip_pkg::RANGE_INT32;
                1: mode = aip_pkg::RANGE_S8;
                2: mode = RANGE_SPARE7;
                3: mode = aip_pkg::RANGE_U8;
                4: mode = aip_pkg::RANGE_S16;
                5: mode = aip_pkg::RANGE_UINT31;
                6: mode = RANGE_SPARE6;
                default: mode = RANGE_SPARE5;
            endcase
            set_range_mode(mode);
            no_stall = (p == 2);
            target = symbols_sent + 185;
            while (symbols_sent < target) begin
                build_text();
                send_buf();
                if ($urandom_range(0, 49) == 0)
                    settle_block();
            end
            no_stall = 1'b0;
        end
    endtask

    // ---------------- main sequence ----------------

    initial begin
        aresetn          = 1'b0;
        s_valid          = 1'b0;
        s_character      = '0;
        s_end_marker     = 1'b0;
        range_mode_we    = 1'b0;
        range_mode_wdata = aip_pkg::RANGE_INT32;
        fails            = 0;
        symbols_sent     = 0;
        no_stall         = 1'b0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_grammar_cases();
        test_range_limits();
        test_spare_modes();
        test_pause_for_results();
        test_random_text();

        settle_block();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fails == 0)
            $display("** ascii_integer_parser_unit: PASSED **");
        else
            $display("** ascii_integer_parser_unit: FAILED **");
        $finish;
    end

endmodule

FILE: files.f
design/aip_pkg.sv
design/aip_parse_core.sv
design/ascii_integer_parser_unit.sv
design/aip_checker.sv
verif/tb_ascii_integer_parser_unit.sv
